// ===== src/rat_pkg.sv =====
// Shared types and constants of the remote address id table.
package rat_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned STATUS_W = 3;

  // job queue between front and back; depth must stay a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_IP_CONFLICT = 3'd1,
    ST_DUP_PORT    = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    K_ADD    = 2'd0,
    K_REMOVE = 2'd1,
    K_LIST   = 2'd2,
    K_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_word_t;

endpackage

// ===== src/rat_req_if.sv =====
// Command channel of the remote address id table.
interface rat_req_if;
  import rat_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   addr_id;
  logic [IP_W-1:0]   ip_address;
  logic [PORT_W-1:0] port;

  modport source (output valid, command, addr_id, ip_address, port, input ready);
  modport sink   (input valid, command, addr_id, ip_address, port, output ready);
endinterface

// ===== src/rat_rsp_if.sv =====
// Result channel of the remote address id table.
interface rat_rsp_if;
  import rat_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IP_W-1:0]     dest_ip;
  logic [PORT_W-1:0]   dest_port;
  logic                port_valid;
  logic                last;

  modport source (output valid, status, dest_ip, dest_port, port_valid, last, input ready);
  modport sink   (input valid, status, dest_ip, dest_port, port_valid, last, output ready);
endinterface

// ===== src/rat_front.sv =====
// Front end: accepts command words, drops unused codes, flags ids beyond the table.
module rat_front #(
  parameter int unsigned NUM_IDS = 256
) (
  rat_req_if.sink          req_i,
  input  logic             q_full_i,
  output rat_pkg::q_word_t push_o
);
  import rat_pkg::*;

  localparam logic [ID_W:0] IdLimit = (ID_W+1)'(NUM_IDS);

  logic  accept;
  logic  in_range;
  kind_e kind;
  logic  known;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, req_i.addr_id} < IdLimit;

  always_comb begin
    known = 1'b1;
    kind  = K_REJECT;
    unique case (req_i.command)
      CMD_ADD:    kind = K_ADD;
      CMD_REMOVE: kind = K_REMOVE;
      CMD_LIST:   kind = K_LIST;
      default:    known = 1'b0;
    endcase
    if (!in_range) begin
      kind = K_REJECT;
    end
  end

  always_comb begin
    push_o.valid    = accept && known;
    push_o.job.kind = kind;
    // rejected words carry id 0 so the back end never indexes past the table
    push_o.job.id   = in_range ? req_i.addr_id : '0;
    push_o.job.ip   = req_i.ip_address;
    push_o.job.port = req_i.port;
  end

endmodule

// ===== src/rat_queue.sv =====
// Short job queue between the front and back ends.
module rat_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rat_pkg::q_word_t push_i,
  output logic             full_o,
  output rat_pkg::q_word_t head_o,
  input  logic             pop_i
);
  import rat_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o       = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.job   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i.valid && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (!push_i.valid && pop_i) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.job;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o || pop_i)
    else $error("job queue overrun");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("job queue underrun");

endmodule

// ===== src/rat_back.sv =====
// Back end: table storage, port scan and result register.
module rat_back #(
  parameter int unsigned NUM_IDS      = 256,
  parameter int unsigned PORTS_PER_ID = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rat_pkg::q_word_t head_i,
  output logic             pop_o,
  rat_rsp_if.source        rsp_o
);
  import rat_pkg::*;

  localparam int unsigned IDX_W   = $clog2(NUM_IDS);
  localparam int unsigned CNT_W   = $clog2(PORTS_PER_ID + 1);
  localparam int unsigned NSLOTS  = NUM_IDS * PORTS_PER_ID;
  localparam int unsigned SLOT_AW = $clog2(NSLOTS);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_LOOK     = 6'b000010,
    S_SCAN_RD  = 6'b000100,
    S_SCAN_CMP = 6'b001000,
    S_LIST_RD  = 6'b010000,
    S_LIST_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  job_t   job_q, job_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] idx_nxt;

  logic [NUM_IDS-1:0] valid_q;
  logic [IP_W-1:0]    ip_mem   [NUM_IDS];
  logic [CNT_W-1:0]   cnt_mem  [NUM_IDS];
  logic [PORT_W-1:0]  slot_mem [NSLOTS];
  logic [IP_W-1:0]    ip_rd_q;
  logic [CNT_W-1:0]   cnt_rd_q;
  logic [PORT_W-1:0]  slot_rd_q;

  logic [IDX_W-1:0]   job_id;
  logic [IDX_W-1:0]   rd_id;
  logic               hit;
  logic [CNT_W-1:0]   cnt_eff;
  logic [SLOT_AW-1:0] slot_base;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [SLOT_AW-1:0] slot_waddr;

  logic             ip_we;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wdata;
  logic             slot_we;
  logic             valid_set;
  logic             valid_clr;

  logic              out_free;
  logic              emit;
  status_e           e_status;
  logic [IP_W-1:0]   e_ip;
  logic [PORT_W-1:0] e_port;
  logic              e_pv;
  logic              e_last;

  logic              rsp_valid_q;
  status_e           status_q;
  logic [IP_W-1:0]   ip_q;
  logic [PORT_W-1:0] port_q;
  logic              pv_q;
  logic              last_q;

  assign job_id     = job_q.id[IDX_W-1:0];
  assign rd_id      = (state_q == S_IDLE) ? head_i.job.id[IDX_W-1:0] : job_id;
  assign hit        = valid_q[job_id];
  assign cnt_eff    = hit ? cnt_rd_q : '0;
  assign slot_base  = SLOT_AW'(job_id) * SLOT_AW'(PORTS_PER_ID);
  assign slot_raddr = slot_base + SLOT_AW'(idx_q);
  // a free id counts as 0 ports, so a new entry and an append share this address
  assign slot_waddr = slot_base + SLOT_AW'(cnt_eff);
  assign cnt_wdata  = cnt_eff + CNT_W'(job_q.port != '0);
  assign idx_nxt    = idx_q + CNT_W'(1);
  assign out_free   = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_ip      = '0;
    e_port    = '0;
    e_pv      = 1'b0;
    e_last    = 1'b1;
    ip_we     = 1'b0;
    cnt_we    = 1'b0;
    slot_we   = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          job_d   = head_i.job;
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (job_q.kind)
            K_REMOVE: begin
              emit      = 1'b1;
              valid_clr = hit;
              e_status  = hit ? ST_OK : ST_NOT_FOUND;
            end
            K_LIST: begin
              if (!hit) begin
                emit     = 1'b1;
                e_status = ST_NOT_FOUND;
              end else if (cnt_rd_q == '0) begin
                emit = 1'b1;
                e_ip = ip_rd_q;
              end else begin
                idx_d   = '0;
                state_d = S_LIST_RD;
              end
            end
            K_ADD: begin
              if (!hit) begin
                emit      = 1'b1;
                valid_set = 1'b1;
                ip_we     = 1'b1;
                cnt_we    = 1'b1;
                slot_we   = job_q.port != '0;
              end else if (ip_rd_q != job_q.ip) begin
                emit     = 1'b1;
                e_status = ST_IP_CONFLICT;
              end else if (job_q.port == '0) begin
                emit = 1'b1;
              end else if (cnt_rd_q == '0) begin
                emit    = 1'b1;
                cnt_we  = 1'b1;
                slot_we = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              emit     = 1'b1;
              e_status = ST_NOT_FOUND;
            end
          endcase
        end
      end

      S_SCAN_RD: state_d = S_SCAN_CMP;

      S_SCAN_CMP: begin
        if (slot_rd_q == job_q.port) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = ST_DUP_PORT;
            state_d  = S_IDLE;
          end
        end else if (idx_nxt == cnt_rd_q) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
            if (cnt_rd_q >= CNT_W'(PORTS_PER_ID)) begin
              e_status = ST_FULL;
            end else begin
              cnt_we  = 1'b1;
              slot_we = 1'b1;
            end
          end
        end else begin
          idx_d   = idx_nxt;
          state_d = S_SCAN_RD;
        end
      end

      S_LIST_RD: state_d = S_LIST_OUT;

      S_LIST_OUT: begin
        if (out_free) begin
          emit   = 1'b1;
          e_ip   = ip_rd_q;
          e_port = slot_rd_q;
          e_pv   = 1'b1;
          e_last = idx_nxt == cnt_rd_q;
          if (e_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_nxt;
            state_d = S_LIST_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (valid_set) begin
        valid_q[job_id] <= 1'b1;
      end else if (valid_clr) begin
        valid_q[job_id] <= 1'b0;
      end
      if (emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    idx_q <= idx_d;
    if (emit) begin
      status_q <= e_status;
      ip_q     <= e_ip;
      port_q   <= e_port;
      pv_q     <= e_pv;
      last_q   <= e_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ip_we) begin
      ip_mem[job_id] <= job_q.ip;
    end
    ip_rd_q <= ip_mem[rd_id];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[job_id] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[rd_id];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= job_q.port;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.dest_ip    = ip_q;
  assign rsp_o.dest_port  = port_q;
  assign rsp_o.port_valid = pv_q;
  assign rsp_o.last       = last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back end state not one-hot");

  a_idx_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP || state_q == S_LIST_OUT) |-> hit && idx_q < cnt_rd_q)
    else $error("slot index past port count");

  a_port_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && pv_q |-> status_q == ST_OK)
    else $error("listed port with error status");

  a_multi_only_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !last_q |-> pv_q)
    else $error("non-final word outside a port list");

endmodule

// ===== src/remote_address_id_table.sv =====
// Top level of the remote address id table.
//
//   channel  dir  modport  words per command
//   req_i    in   sink     one (add, remove, list)
//   rsp_o    out  source   one, or one per listed port for list
//
// Remove, reject and add to a free id pass S_IDLE and S_LOOK in the back end; add
// to a bound id then steps S_SCAN_RD and S_SCAN_CMP per port compared; list steps
// S_LIST_RD and S_LIST_OUT per port listed, as the port slot memory has a registered read.
// Reset clears the per-id valid flops at once; there is no clearing pass.
// A 2-word job queue takes up to 2 words while the back end or rsp_o stalls;
// req_i ready drops while it is full.
module remote_address_id_table #(
  parameter int unsigned NUM_IDS      = 256,
  parameter int unsigned PORTS_PER_ID = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rat_req_if.sink   req_i,
  rat_rsp_if.source rsp_o
);
  import rat_pkg::*;

  q_word_t push;
  q_word_t head;
  logic    q_full;
  logic    pop;

  rat_front #(
    .NUM_IDS (NUM_IDS)
  ) u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  rat_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  rat_back #(
    .NUM_IDS      (NUM_IDS),
    .PORTS_PER_ID (PORTS_PER_ID)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench for the remote address id table: directed and random commands, checked per word.
`timescale 1ns / 100ps

module testbench;
  import rat_pkg::*;

  localparam int unsigned NUM_IDS      = 256;
  localparam int unsigned PORTS_PER_ID = 4;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned POOL_SIZE    = 8;

  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    status_e           status;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic              port_valid;
    logic              last;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  rat_req_if req_if ();
  rat_rsp_if rsp_if ();

  remote_address_id_table #(
    .NUM_IDS      (NUM_IDS),
    .PORTS_PER_ID (PORTS_PER_ID)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // table mirror
  bit                entry_bound [NUM_IDS];
  logic [IP_W-1:0]   bound_ip    [NUM_IDS];
  int unsigned       port_cnt    [NUM_IDS];
  logic [PORT_W-1:0] port_list   [NUM_IDS][PORTS_PER_ID];

  reply_t      expected_replies[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          pacing;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic reply_t make_reply(status_e status, logic [IP_W-1:0] ip,
                                        logic [PORT_W-1:0] port, logic port_valid,
                                        logic last);
    reply_t r;
    r.status     = status;
    r.ip         = ip;
    r.port       = port;
    r.port_valid = port_valid;
    r.last       = last;
    return r;
  endfunction

  // append one word to the tail of the expected list
  function automatic void expect_word(reply_t r);
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  function automatic status_e apply_add(int unsigned id, logic [IP_W-1:0] ip,
                                        logic [PORT_W-1:0] port);
    int unsigned n;
    if (!entry_bound[id]) begin
      entry_bound[id] = 1'b1;
      bound_ip[id]    = ip;
      port_cnt[id]    = 0;
      if (port != '0) begin
        port_list[id][0] = port;
        port_cnt[id]     = 1;
      end
      return ST_OK;
    end
    if (bound_ip[id] != ip) return ST_IP_CONFLICT;
    if (port == '0) return ST_OK;
    n = port_cnt[id];
    for (int unsigned i = 0; i < n; i++)
      if (port_list[id][i] == port) return ST_DUP_PORT;
    if (n >= PORTS_PER_ID) return ST_FULL;
    port_list[id][n] = port;
    port_cnt[id]     = n + 1;
    return ST_OK;
  endfunction

  // queue the words one accepted command should produce
  function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] addr_id,
                                          logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
    int unsigned id;
    int unsigned n;
    id = 32'(addr_id);
    if (cmd == CMD_UNUSED) return;
    if (id >= NUM_IDS) begin
      expect_word(make_reply(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1));
    end else if (cmd == CMD_ADD) begin
      expect_word(make_reply(apply_add(id, ip, port), '0, '0, 1'b0, 1'b1));
    end else if (!entry_bound[id]) begin
      expect_word(make_reply(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1));
    end else if (cmd == CMD_REMOVE) begin
      entry_bound[id] = 1'b0;
      bound_ip[id]    = '0;
      port_cnt[id]    = 0;
      expect_word(make_reply(ST_OK, '0, '0, 1'b0, 1'b1));
    end else begin
      n = port_cnt[id];
      if (n == 0)
        expect_word(make_reply(ST_OK, bound_ip[id], '0, 1'b0, 1'b1));
      for (int unsigned i = 0; i < n; i++)
        expect_word(make_reply(ST_OK, bound_ip[id], port_list[id][i], 1'b1, i + 1 == n));
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!pacing) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // caller sits right after a rising edge
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] addr_id,
                           logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= cmd;
    req_if.addr_id    <= addr_id;
    req_if.ip_address <= ip;
    req_if.port       <= port;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_command(cmd, addr_id, ip, port);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if (pacing && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected word: status %0d ip %h port %h port_valid %b last %b",
                 $time, rsp_if.status, rsp_if.dest_ip, rsp_if.dest_port,
                 rsp_if.port_valid, rsp_if.last);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("dest_ip", want.ip, rsp_if.dest_ip);
        check_field("dest_port", 32'(want.port), 32'(rsp_if.dest_port));
        check_field("port_valid", 32'(want.port_valid), 32'(rsp_if.port_valid));
        check_field("last", 32'(want.last), 32'(rsp_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_add_rules();
    send_word(CMD_LIST, 8'd0, '0, '0);             // free id
    send_word(CMD_REMOVE, 8'd0, '0, '0);           // free id
    send_word(CMD_ADD, 8'd0, '0, '0);              // bind without a port
    send_word(CMD_LIST, 8'd0, '0, '0);             // bound, empty list
    send_word(CMD_ADD, 8'd0, '0, 16'hffff);
    send_word(CMD_ADD, 8'd0, '0, 16'hffff);        // duplicate
    send_word(CMD_ADD, 8'd0, '0, 16'd1);
    send_word(CMD_ADD, 8'd0, '0, 16'd2);
    send_word(CMD_ADD, 8'd0, '0, 16'd3);
    send_word(CMD_ADD, 8'd0, '0, 16'h8000);        // list full
    send_word(CMD_ADD, 8'd0, '0, 16'd1);           // duplicate wins over full
    send_word(CMD_ADD, 8'd0, 32'hffff_ffff, 16'd5); // other address
    send_word(CMD_ADD, 8'd0, '0, '0);              // no port on a full list
  endtask

  task automatic test_list_and_remove();
    send_word(CMD_LIST, 8'd0, '0, '0);
    send_word(CMD_REMOVE, 8'd0, '0, '0);
    send_word(CMD_LIST, 8'd0, '0, '0);
    send_word(CMD_ADD, 8'd255, 32'hffff_ffff, 16'habcd); // new id takes its port
    send_word(CMD_LIST, 8'd255, '0, '0);
  endtask

  task automatic test_unused_command();
    send_word(CMD_UNUSED, 8'd255, 32'hffff_ffff, 16'hffff);
    send_word(CMD_LIST, 8'd255, '0, '0);
    send_word(CMD_REMOVE, 8'd255, '0, '0);
    // stale slots behind a rebound id stay hidden
    send_word(CMD_ADD, 8'd255, 32'h1234_5678, '0);
    send_word(CMD_LIST, 8'd255, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [ID_W-1:0]   pool_id   [POOL_SIZE];
    logic [IP_W-1:0]   pool_ip   [POOL_SIZE];
    logic [PORT_W-1:0] pool_port [POOL_SIZE];
    int unsigned       sent;
    int unsigned       r;
    int unsigned       k;
    logic [CMD_W-1:0]  cmd;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_id[i]   = ID_W'($urandom_range(0, 255));
      pool_ip[i]   = $urandom();
      pool_port[i] = PORT_W'($urandom_range(1, 65535));
    end
    pool_id[0] = 8'd0;
    pool_id[1] = 8'd255;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pacing = ((sent / 40) % 3) != 2;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        cmd = CMD_W'($urandom_range(0, 3));
        send_word(cmd, ID_W'($urandom_range(0, 255)), $urandom(),
                  PORT_W'($urandom_range(0, 65535)));
        if (cmd != CMD_UNUSED) sent++;
      end else if (r < 9) begin
        send_word(CMD_UNUSED, ID_W'($urandom_range(0, 255)), $urandom(),
                  PORT_W'($urandom_range(0, 65535)));
      end else begin
        k = $urandom_range(0, POOL_SIZE - 1);
        r = $urandom_range(0, 99);
        if (r < 58) begin
          ip   = ($urandom_range(0, 99) < 85) ? pool_ip[k] : $urandom();
          port = ($urandom_range(0, 9) == 0) ? '0 : pool_port[$urandom_range(0, POOL_SIZE - 1)];
          send_word(CMD_ADD, pool_id[k], ip, port);
        end else if (r < 86) begin
          send_word(CMD_LIST, pool_id[k], $urandom(), PORT_W'($urandom_range(0, 65535)));
        end else begin
          send_word(CMD_REMOVE, pool_id[k], $urandom(), PORT_W'($urandom_range(0, 65535)));
          if ($urandom_range(0, 1) == 1) pool_ip[k] = $urandom();
        end
        sent++;
      end
    end
    pacing = 1'b1;
  endtask

  initial begin
    pacing            = 1'b1;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_ADD;
    req_if.addr_id    = '0;
    req_if.ip_address = '0;
    req_if.port       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_rules();
    test_list_and_remove();
    test_unused_command();
    test_random_traffic();

    req_if.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
